>>> rtl/b64enc_pkg.sv
`default_nettype none
package b64enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_DIGIT = 8'h30;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // one request worth of characters: up to two sextets, then padding
    typedef struct packed {
        logic [5:0] sext0;
        logic [5:0] sext1;
        logic       has_sext1;
        logic [1:0] cnt_m1;
        logic       last;
    } t_cmd;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                c = CH_UPPER + w;
            end else if (v < 6'd52) begin
                c = CH_LOWER + (w - 8'd26);
            end else if (v < 6'd62) begin
                c = CH_DIGIT + (w - 8'd52);
            end else if (v == 6'd62) begin
                c = CH_PLUS;
            end else begin
                c = CH_SLASH;
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/b64enc_if.sv
`default_nettype none
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

>>> rtl/base64_stream_encoder_unit.sv
`default_nettype none
// channel   dir  payload                      note
// i_byte    in   data_byte[7:0], last_byte    raw bytes, last_byte closes a message
// o_char    out  out_char[7:0], last_char     base64 ascii, last_char on final char
//
// one character leaves per cycle while o_char is ready; a byte yields one or two
// characters, the final byte of a message up to four: about four per three bytes
// a first character passes the request queue, r_cmd and the output register
// reset: synchronous, active low; clears phase, queue and output stage
// the request queue lets byte intake run on while characters wait on o_char
module base64_stream_encoder_unit #(
    parameter int unsigned P_QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    b64enc_byte_if.sink   i_byte,
    b64enc_char_if.source o_char
);

    b64enc_pkg::t_cmd front_cmd;
    b64enc_pkg::t_cmd queue_cmd;
    logic             front_push;
    logic             queue_full;
    logic             queue_valid;
    logic             back_pop;

    b64enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_push      (front_push),
        .o_cmd       (front_cmd),
        .i_full      (queue_full)
    );

    b64enc_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd)
    );

    b64enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .i_cmd   (queue_cmd),
        .o_valid (o_char.valid),
        .i_ready (o_char.ready),
        .o_char  (o_char.out_char),
        .o_last  (o_char.last_char)
    );

endmodule
`default_nettype wire

>>> rtl/b64enc_front.sv
`default_nettype none
module b64enc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output logic                   o_push,
    output b64enc_pkg::t_cmd       o_cmd,
    input  wire logic              i_full
);

    b64enc_pkg::t_phase r_phase;
    b64enc_pkg::t_phase n_phase;
    logic [3:0]         r_left;
    logic [3:0]         n_left;
    logic               accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // next phase and leftover bits
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (accept) begin
            case (r_phase)
                b64enc_pkg::PH_1: begin
                    n_phase = b64enc_pkg::PH_2;
                    n_left  = i_data_byte[3:0];
                end
                b64enc_pkg::PH_2: begin
                    n_phase = b64enc_pkg::PH_0;
                    n_left  = 4'd0;
                end
                default: begin
                    n_phase = b64enc_pkg::PH_1;
                    n_left  = {2'b00, i_data_byte[1:0]};
                end
            endcase
            if (i_last_byte) begin
                n_phase = b64enc_pkg::PH_0;
                n_left  = 4'd0;
            end
        end
    end

    // request for the back end
    always_comb begin
        o_cmd      = '0;
        o_cmd.last = i_last_byte;
        case (r_phase)
            b64enc_pkg::PH_1: begin
                o_cmd.sext0     = {r_left[1:0], i_data_byte[7:4]};
                o_cmd.sext1     = {i_data_byte[3:0], 2'b00};
                o_cmd.has_sext1 = i_last_byte;
                o_cmd.cnt_m1    = i_last_byte ? 2'd2 : 2'd0;
            end
            b64enc_pkg::PH_2: begin
                o_cmd.sext0     = {r_left, i_data_byte[7:6]};
                o_cmd.sext1     = i_data_byte[5:0];
                o_cmd.has_sext1 = 1'b1;
                o_cmd.cnt_m1    = 2'd1;
            end
            default: begin
                o_cmd.sext0     = i_data_byte[7:2];
                o_cmd.sext1     = {i_data_byte[1:0], 4'b0000};
                o_cmd.has_sext1 = i_last_byte;
                o_cmd.cnt_m1    = i_last_byte ? 2'd3 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64enc_pkg::PH_0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64enc_queue.sv
`default_nettype none
module b64enc_queue #(
    parameter int unsigned P_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64enc_pkg::t_cmd  i_cmd,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output b64enc_pkg::t_cmd       o_cmd
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    b64enc_pkg::t_cmd r_mem [P_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push;
    logic             pop;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64enc_back.sv
`default_nettype none
module b64enc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_pop,
    input  wire b64enc_pkg::t_cmd  i_cmd,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_char,
    output logic                   o_last
);

    b64enc_pkg::t_cmd r_cmd;
    logic             r_busy;
    logic [1:0]       r_pos;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             can_load;
    logic             emit;
    logic             final_char;
    logic [7:0]       cur_char;

    assign can_load   = !r_out_valid || i_ready;
    assign emit       = r_busy && can_load;
    assign final_char = (r_pos == r_cmd.cnt_m1);
    assign o_pop      = i_valid && (!r_busy || (emit && final_char));

    always_comb begin
        if (r_pos == 2'd0) begin
            cur_char = b64enc_pkg::sextet_char(r_cmd.sext0);
        end else if (r_pos == 2'd1 && r_cmd.has_sext1) begin
            cur_char = b64enc_pkg::sextet_char(r_cmd.sext1);
        end else begin
            cur_char = b64enc_pkg::CH_PAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_char <= cur_char;
            r_out_last <= final_char && r_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= 2'd0;
            end else if (emit) begin
                if (final_char) begin
                    r_busy <= 1'b0;
                    r_pos  <= 2'd0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire
